### hdl/tgag_pkg.sv
package tgag_pkg;

  localparam int ADDR_WIDTH      = 32;
  localparam int COUNT_WIDTH     = 16;
  localparam int MAX_INNER       = 64;
  localparam int SLICE_WIDTH     = $clog2(MAX_INNER + 1);
  localparam int POS_WIDTH       = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int INNER_WIDTH     = 7;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int INDEX_WIDTH     = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTER_COUNT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INNER_COUNT = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INDEX_COUNT = 2'd3;

  // One classified index: where its slice starts on both sides and how long it is.
  typedef struct packed {
    logic [ADDR_WIDTH-1:0]  src_base;
    logic [ADDR_WIDTH-1:0]  dst_base;
    logic [SLICE_WIDTH-1:0] n;
    logic                   err;
  } slice_desc_t;

endpackage

### hdl/tgag_front.sv
module tgag_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [tgag_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tgag_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tgag_pkg::INDEX_WIDTH-1:0]     in_index,
  input  logic                                 q_full,
  output logic                                 q_push,
  output tgag_pkg::slice_desc_t                q_wdata
);
  import tgag_pkg::*;

  logic [COUNT_WIDTH-1:0] outer_count;
  logic [COUNT_WIDTH-1:0] axis_length;
  logic [INNER_WIDTH-1:0] inner_count;
  logic [COUNT_WIDTH-1:0] index_count;

  logic [COUNT_WIDTH-1:0] index_position;
  logic [COUNT_WIDTH-1:0] outer_position;
  logic [ADDR_WIDTH-1:0]  outer_source_base;
  logic [ADDR_WIDTH-1:0]  dest_running_address;

  logic [SLICE_WIDTH-1:0]             n;
  logic [INDEX_WIDTH:0]               idx_adj;
  logic                               err;
  logic [COUNT_WIDTH+SLICE_WIDTH-1:0] idx_prod;
  logic [COUNT_WIDTH+SLICE_WIDTH-1:0] block_prod;
  logic [COUNT_WIDTH-1:0]             index_next;
  logic [COUNT_WIDTH-1:0]             outer_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_count <= COUNT_WIDTH'(1);
      axis_length <= COUNT_WIDTH'(1);
      inner_count <= INNER_WIDTH'(1);
      index_count <= COUNT_WIDTH'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OUTER_COUNT: outer_count <= cfg_data[COUNT_WIDTH-1:0];
        REG_AXIS_LENGTH: axis_length <= cfg_data[COUNT_WIDTH-1:0];
        REG_INNER_COUNT: inner_count <= cfg_data[INNER_WIDTH-1:0];
        REG_INDEX_COUNT: index_count <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Slice length is clamped to 1..MAX_INNER.
  always_comb begin
    if (inner_count == '0) begin
      n = SLICE_WIDTH'(1);
    end else if (INNER_WIDTH'(inner_count) > INNER_WIDTH'(MAX_INNER)) begin
      n = SLICE_WIDTH'(MAX_INNER);
    end else begin
      n = SLICE_WIDTH'(inner_count);
    end
  end

  // Negative indices count from the end of the axis.
  always_comb begin
    if (in_index[INDEX_WIDTH-1]) begin
      idx_adj = {1'b1, in_index} + {{(INDEX_WIDTH+1-COUNT_WIDTH){1'b0}}, axis_length};
    end else begin
      idx_adj = {1'b0, in_index};
    end
    err = idx_adj[INDEX_WIDTH] ||
          (idx_adj[INDEX_WIDTH-1:0] >= {{(INDEX_WIDTH-COUNT_WIDTH){1'b0}}, axis_length});
  end

  assign idx_prod   = {{SLICE_WIDTH{1'b0}}, idx_adj[COUNT_WIDTH-1:0]} *
                      {{COUNT_WIDTH{1'b0}}, n};
  assign block_prod = {{SLICE_WIDTH{1'b0}}, axis_length} * {{COUNT_WIDTH{1'b0}}, n};
  assign index_next = index_position + COUNT_WIDTH'(1);
  assign outer_next = outer_position + COUNT_WIDTH'(1);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_wdata.src_base = err ? '0
                     : outer_source_base + ADDR_WIDTH'(idx_prod);
    q_wdata.dst_base = dest_running_address;
    q_wdata.n        = n;
    q_wdata.err      = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_position       <= '0;
      outer_position       <= '0;
      outer_source_base    <= '0;
      dest_running_address <= '0;
    end else if (q_push) begin
      dest_running_address <= dest_running_address + ADDR_WIDTH'(n);
      if (index_next >= index_count) begin
        index_position <= '0;
        if (outer_next >= outer_count) begin
          outer_position       <= '0;
          outer_source_base    <= '0;
          dest_running_address <= '0;
        end else begin
          outer_position    <= outer_next;
          outer_source_base <= outer_source_base + ADDR_WIDTH'(block_prod);
        end
      end else begin
        index_position <= index_next;
      end
    end
  end

endmodule

### hdl/tgag_queue.sv
module tgag_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tgag_pkg::slice_desc_t wdata,
  output logic                  full,
  input  logic                  pop,
  output tgag_pkg::slice_desc_t rdata,
  output logic                  empty
);
  import tgag_pkg::*;

  slice_desc_t             slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr;
  logic [QPTR_WIDTH-1:0]   rd_ptr;
  logic [QCOUNT_WIDTH-1:0] count;

  assign full  = (count == QCOUNT_WIDTH'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_WIDTH'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCOUNT_WIDTH'(1);
        2'b01:   count <= count - QCOUNT_WIDTH'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= QCOUNT_WIDTH'(QUEUE_DEPTH)) && ((wr_ptr == rd_ptr) == (empty || full)))
    else $error("queue count and pointers disagree");

endmodule

### hdl/tgag_back.sv
module tgag_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tgag_pkg::slice_desc_t           q_rdata,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tgag_pkg::ADDR_WIDTH-1:0] out_src,
  output logic [tgag_pkg::ADDR_WIDTH-1:0] out_dst,
  output logic                            out_last,
  output logic                            out_err
);
  import tgag_pkg::*;

  slice_desc_t          cur;
  logic                 active;
  logic [POS_WIDTH-1:0] j;
  logic                 advance;
  logic                 at_last;

  assign advance = active && (!out_valid || out_ready);
  assign at_last = ((SLICE_WIDTH'(j) + SLICE_WIDTH'(1)) == cur.n);
  assign q_pop   = !q_empty && (!active || (advance && at_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
    if (advance) begin
      out_src  <= cur.err ? '0 : cur.src_base + ADDR_WIDTH'(j);
      out_dst  <= cur.dst_base + ADDR_WIDTH'(j);
      out_last <= at_last;
      out_err  <= cur.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        active <= 1'b1;
        j      <= '0;
      end else if (advance) begin
        if (at_last) begin
          active <= 1'b0;
        end else begin
          j <= j + POS_WIDTH'(1);
        end
      end
    end
  end

  a_pos_in_slice: assert property (@(posedge clk) disable iff (rst)
    active |-> (SLICE_WIDTH'(j) < cur.n))
    else $error("element position beyond slice length");
  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    active |-> ((cur.n != '0) && (cur.n <= SLICE_WIDTH'(MAX_INNER))))
    else $error("slice length outside legal range");
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("generated address pair not presented");

endmodule

### hdl/tensor_gather_address_generator.sv
// Gather address generator: each index transfer on the slave stream produces
// 1 to 64 address pairs (the clamped inner_count) on the master stream; the
// slice walker emits a slice one pair per clock while the receiver is ready.
// The classifier takes one index per cycle while its two-entry descriptor
// queue has room, so indices are taken ahead of the walker. Negative indices
// have axis_length added; an index still outside the axis gives a slice with
// index_error set in tuser and a source address of zero, which must not be
// read. Configuration is written through cfg_wr_en, cfg_index and cfg_data
// and should only change while no transfer is pending.
module tensor_gather_address_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  // Register index: 0 outer_count, 1 axis_length, 2 inner_count, 3 index_count.
  input  logic                                 cfg_wr_en,
  input  logic [tgag_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tgag_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: [31:0] gather_index (signed).
  input  logic [31:0]                          s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: [31:0] src_address, [63:32] dst_address.
  output logic [63:0]                          m_axis_tdata,
  // tlast: last_of_slice.
  output logic                                 m_axis_tlast,
  // tuser: [0] index_error.
  output logic                                 m_axis_tuser
);
  import tgag_pkg::*;

  slice_desc_t           q_wdata;
  slice_desc_t           q_rdata;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [ADDR_WIDTH-1:0] src_addr;
  logic [ADDR_WIDTH-1:0] dst_addr;

  // The classifier wraps the index, checks it against the axis and keeps the
  // index, outer-block and destination counters.
  tgag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_index  (s_axis_tdata[INDEX_WIDTH-1:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Slice descriptors wait here so either side can stall on its own.
  tgag_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The walker steps through each slice and drives the output register.
  tgag_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_src   (src_addr),
    .out_dst   (dst_addr),
    .out_last  (m_axis_tlast),
    .out_err   (m_axis_tuser)
  );

  assign m_axis_tdata = {dst_addr[31:0], src_addr[31:0]};

endmodule

### bench/tb_tensor_gather_address_generator.sv
module tb_tensor_gather_address_generator;
  import tgag_pkg::*;

  // A cycle budget for stretches in which neither stream moves a transfer.
  // The longest legitimate quiet stretch is a receiver stall or a sender gap
  // plus a register update between shapes, far below this.
  localparam int QUIET_LIMIT = 1000;

  // One address pair as it should appear on the master stream.
  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    logic        last;
    logic        err;
  } addr_pair_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  // tdata: [31:0] gather_index (signed).
  logic [31:0]                s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  // tdata: [31:0] src_address, [63:32] dst_address.
  logic [63:0]                m_axis_tdata;
  // tlast: last_of_slice.
  logic                       m_axis_tlast;
  // tuser: [0] index_error.
  logic                       m_axis_tuser;

  tensor_gather_address_generator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Shadow copy of the four shape registers, updated whenever the bench
  // writes one, so the predictor always sees what the block sees.
  logic [15:0] cfg_outer;
  logic [15:0] cfg_axis;
  logic [6:0]  cfg_inner;
  logic [15:0] cfg_count;

  // Shadow copy of the walking state: where the next index sits in its
  // block, which outer block is current, and the running address bases.
  logic [15:0] index_pos;
  logic [15:0] outer_pos;
  logic [31:0] src_block_base;
  logic [31:0] dst_next;

  // Address pairs predicted but not yet seen on the master stream, oldest first.
  addr_pair_t pending_pairs[$];
  addr_pair_t head_pair;

  // When set, neither side inserts gaps or stalls, so the block runs flat out.
  bit no_idle = 1'b0;

  int fail_count    = 0;
  int items_sent    = 0;
  int pairs_checked = 0;
  int shapes_used   = 0;
  int quiet_cycles  = 0;

  // Expand one accepted index into the address pairs of its slice and then
  // advance the position counters exactly as the block does. A negative
  // index counts from the end of the axis; one still outside the axis yields
  // a flagged slice whose source address carries no meaning.
  task automatic predict_slice(input logic [31:0] raw);
    longint      wrapped;
    longint      axis_len;
    int unsigned n;
    logic        bad;
    logic [31:0] base;
    logic [15:0] next_pos;
    addr_pair_t  p;
    n = (cfg_inner == 0) ? 1 : ((cfg_inner > MAX_INNER) ? MAX_INNER : cfg_inner);
    axis_len = longint'(cfg_axis);
    wrapped = longint'($signed(raw));
    if (wrapped < 0) begin
      wrapped = wrapped + axis_len;
    end
    bad = (wrapped < 0) || (wrapped >= axis_len);
    base = bad ? 32'd0 : src_block_base + 32'(wrapped) * 32'(n);
    for (int j = 0; j < n; j++) begin
      p.src  = bad ? 32'd0 : base + j;
      p.dst  = dst_next + j;
      p.last = (j == n - 1);
      p.err  = bad;
      pending_pairs.push_back(p);
    end
    dst_next = dst_next + n;
    // Index position wraps at index_count; each wrap moves to the next outer
    // block, and wrapping past outer_count starts the whole tensor over.
    // A count register of zero behaves like one, which the compare gives.
    next_pos = index_pos + 16'd1;
    if (next_pos >= cfg_count) begin
      index_pos = '0;
      next_pos = outer_pos + 16'd1;
      if (next_pos >= cfg_outer) begin
        outer_pos      = '0;
        src_block_base = '0;
        dst_next       = '0;
      end else begin
        outer_pos      = next_pos;
        src_block_base = src_block_base + 32'(cfg_axis) * 32'(n);
      end
    end else begin
      index_pos = next_pos;
    end
  endtask

  // Offer one index on the slave stream after a random gap and predict its
  // slice at the edge where the transfer happens. Valid is left high on
  // return; the next call changes or lowers it, or the drain lowers it, at
  // the next falling edge, which always comes before the block could sample it again.
  task automatic send_index(input logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= value;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_slice(value);
    items_sent++;
  endtask

  // Stop offering indices and wait until every predicted pair has come out.
  // Every index produces at least one pair, so an empty queue means the
  // block is idle; a final wait lets its output register settle.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register and mirror the write, with the same masking the
  // block applies, into the shadow copy.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_OUTER_COUNT: cfg_outer = value;
      REG_AXIS_LENGTH: cfg_axis  = value;
      REG_INNER_COUNT: cfg_inner = value[6:0];
      REG_INDEX_COUNT: cfg_count = value;
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [15:0] outer, input logic [15:0] axis,
                           input logic [15:0] inner, input logic [15:0] count);
    write_reg(REG_OUTER_COUNT, outer);
    write_reg(REG_AXIS_LENGTH, axis);
    write_reg(REG_INNER_COUNT, inner);
    write_reg(REG_INDEX_COUNT, count);
    shapes_used++;
  endtask

  // Pick an index for the current shape: mostly inside the axis in either
  // positive or end-relative form, some right at the edges of the axis, and
  // some anywhere in the 32-bit range.
  function automatic logic [31:0] pick_index();
    logic [31:0] a;
    int unsigned k;
    a = 32'(cfg_axis);
    if (cfg_axis == 0) begin
      return $urandom;
    end
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return a;
          1: return -a;
          2: return a - 1;
          default: return ~a;
        endcase
      end
      default: begin
        k = $urandom_range(0, cfg_axis - 1);
        return $urandom_range(0, 1) ? k : -(k + 1);
      end
    endcase
  endfunction

  // After reset every register reads one: a single-element axis and slice.
  task automatic test_reset_defaults();
    send_index(32'd0);
    send_index(32'hFFFF_FFFF);
    send_index(32'd1);
    wait_drained();
  endtask

  // A small shape that walks through both counter wraps, end-relative
  // indices, indices just outside the axis on either side, and the most
  // positive and most negative 32-bit indices.
  task automatic test_small_shape_walk();
    set_shape(16'd2, 16'd5, 16'd3, 16'd3);
    send_index(32'd0);
    send_index(32'd4);
    send_index(-32'sd1);
    send_index(-32'sd5);
    send_index(32'd5);
    send_index(-32'sd6);
    send_index(32'h7FFF_FFFF);
    send_index(32'h8000_0000);
    wait_drained();
  endtask

  // The largest sizes. An all-ones inner_count write saturates to the
  // biggest slice, and a zero inner_count behaves as a single element.
  task automatic test_largest_slice();
    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_index(32'd65534);
    send_index(-32'sd65535);
    send_index(-32'sd65536);
    send_index(32'd65535);
    wait_drained();
    write_reg(REG_INNER_COUNT, 16'd0);
    send_index(32'd7);
    send_index(32'd65534);
    wait_drained();
  endtask

  // With an empty axis no index can be in range.
  task automatic test_zero_axis();
    set_shape(16'd1, 16'd0, 16'd1, 16'd1);
    send_index(32'd0);
    send_index(32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Zero block and outer counts act like one, so every index restarts the
  // tensor and both address bases return to zero.
  task automatic test_zero_counts();
    set_shape(16'd0, 16'd3, 16'd2, 16'd0);
    send_index(32'd2);
    send_index(-32'sd3);
    send_index(32'd1);
    send_index(32'd0);
    wait_drained();
  endtask

  // One index per outer block on the widest shape advances the source base
  // by the largest step each time, with both streams running flat out and
  // the full 64-pair slice behind every index.
  task automatic test_large_source_steps();
    no_idle = 1'b1;
    set_shape(16'hFFFF, 16'hFFFF, 16'd64, 16'd1);
    repeat (40) send_index($urandom_range(0, 65534));
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Random shapes, each fed a run of random indices. Sizes stay small most
  // of the time so slices are short; now and then a shape uses a zero, the
  // largest value or an oversized inner_count with stray upper bits.
  task automatic test_random_shapes();
    logic [15:0] outer;
    logic [15:0] axis;
    logic [15:0] inner;
    logic [15:0] count;
    for (int phase = 0; phase < 6; phase++) begin
      outer = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      axis  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      count = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0: inner = 16'($urandom);
        1: inner = 16'd64;
        default: inner = 16'($urandom_range(1, 8));
      endcase
      set_shape(outer, axis, inner, count);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (20) send_index(pick_index());
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  // Receiver: before each pair it may hold ready low for a random stall, then
  // keeps ready high until a transfer takes place.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare every master transfer with the oldest predicted pair. The
  // source address of a flagged slice is not checked since it has no meaning.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected address pair: dst_address %0h", m_axis_tdata[63:32]);
        fail_count++;
      end else begin
        head_pair = pending_pairs.pop_front();
        pairs_checked++;
        if (m_axis_tuser !== head_pair.err) begin
          $error("index_error mismatch: expected %0b, actual %0b",
                 head_pair.err, m_axis_tuser);
          fail_count++;
        end
        if (!head_pair.err && m_axis_tdata[31:0] !== head_pair.src) begin
          $error("src_address mismatch: expected %0h, actual %0h",
                 head_pair.src, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[63:32] !== head_pair.dst) begin
          $error("dst_address mismatch: expected %0h, actual %0h",
                 head_pair.dst, m_axis_tdata[63:32]);
          fail_count++;
        end
        if (m_axis_tlast !== head_pair.last) begin
          $error("last_of_slice mismatch: expected %0b, actual %0b",
                 head_pair.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long stretch without any transfer on either stream means
  // the block has hung.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_outer      = 16'd1;
    cfg_axis       = 16'd1;
    cfg_inner      = 7'd1;
    cfg_count      = 16'd1;
    index_pos      = '0;
    outer_pos      = '0;
    src_block_base = '0;
    dst_next       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_small_shape_walk();
    test_largest_slice();
    test_zero_axis();
    test_zero_counts();
    test_large_source_steps();
    test_random_shapes();

    // Everything has drained; keep the clock running so that any
    // stray pair it still emits is caught by the checker.
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      $error("%0d predicted address pairs never arrived", pending_pairs.size());
      fail_count++;
    end

    $display("Sent %0d gather indices over %0d shapes, checked %0d address pairs.",
             items_sent, shapes_used, pairs_checked);
    $display("Covered counter wraps, out-of-range indices, size extremes and big source steps.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
